/* hw/rtl/infix_expression_evaluator_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the infix expression evaluator
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// same-cycle implication
`define IEEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define IEEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/ieec_pkg.sv */
// ----------------------------------------------------------------------------
// ieec_pkg
// Types and constants shared by the expression evaluator modules.
// ----------------------------------------------------------------------------
package ieec_pkg;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_DIV_ZERO   = 2'd1,
        ST_TOO_DEEP   = 2'd2,
        ST_UNBALANCED = 2'd3
    } status_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CK_DIGIT,
        CK_OPEN,
        CK_CLOSE,
        CK_ADDSUB,
        CK_MULDIV,
        CK_OTHER
    } char_kind_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIGIT,
        DP_DELIVER,
        DP_READ_BELOW,
        DP_FOLD_ADD,
        DP_ALU_START,
        DP_FOLD_ALU,
        DP_PUSH,
        DP_POP,
        DP_SET_ERR,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t err;
    } dp_cmd_t;

    typedef struct packed {
        char_kind_t kind;
        logic       last;
        logic       in_num;
        logic       err;
        op_t        top_op;
        op_t        rd_op;
        logic       sp_ge2;
        logic       sp_full;
        logic       sp_is1;
        logic       alu_done;
        logic       out_busy;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHAR,
        S_OPEN,
        S_CLOSE,
        S_POP,
        S_TAIL,
        S_COLL,
        S_END_CHK,
        S_FINISH,
        S_FOLD_RD,
        S_FOLD_EX,
        S_FOLD_WAIT
    } ctl_state_t;

endpackage

/* hw/rtl/infix_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// Evaluates a character stream as an integer infix expression.
// ----------------------------------------------------------------------------
// One character is taken per item, and ready drops until the item is done.
// A digit is added into the number accumulator; '(', '*' and '/' push an
// entry, '+' and '-' collapse the level and then push, ')' collapses and
// pops, and other characters are ignored. A number that ends under a pending
// * or /, or a ')' whose enclosing entry carries * or /, folds at once
// through the bit-serial multiply/divide unit. While '+', '-', ')' or the
// last character collapse a level, each + or - entry is folded directly and
// each * or / entry goes through the multiply/divide unit. The last character
// then posts the result. The result sits in an output register, so new
// characters are taken while it waits; a following result waits until the
// previous one is taken.
module infix_expression_evaluator_core
    import ieec_pkg::*;
#(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         character,
    input  logic               is_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic [1:0]         status
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    ieec_controller u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ieec_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .character (character),
        .is_last   (is_last),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .value     (value),
        .status    (status)
    );

endmodule

/* hw/rtl/ieec_alu.sv */
// ----------------------------------------------------------------------------
// ieec_alu
// Iterative multiplier and signed divider, one bit per cycle.
// ----------------------------------------------------------------------------
module ieec_alu
    import ieec_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   is_div,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          div_reg, div_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        shifted   = {acc_reg, y_reg[W-1]};
        diff      = shifted - {1'b0, x_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = is_div;
            neg_next  = a[W-1] ^ b[W-1];
            acc_next  = '0;
            if (is_div)
            begin
                x_next = b[W-1] ? (-b) : b;
                y_next = a[W-1] ? (-a) : a;
            end
            else
            begin
                x_next = a;
                y_next = b;
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // restoring step: keep the remainder if the trial goes negative
                if (!diff[W])
                begin
                    acc_next = diff[W-1:0];
                    y_next   = {y_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = shifted[W-1:0];
                    y_next   = {y_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[W-2:0], 1'b0};
                y_next = {1'b0, y_reg[W-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (-y_reg) : y_reg) : acc_reg;

endmodule

/* hw/rtl/ieec_datapath.sv */
// ----------------------------------------------------------------------------
// ieec_datapath
// Operand and operator stack, number accumulator, error and result registers.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_core_defines.svh"

module ieec_datapath
    import ieec_pkg::*;
#(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        stat,
    input  logic [7:0]        character,
    input  logic              is_last,
    input  logic              out_ready,
    output logic              out_valid,
    output logic signed [31:0] value,
    output logic [1:0]        status
);

    localparam int W     = VALUE_WIDTH;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef struct packed {
        op_t          op;
        logic [W-1:0] val;
    } entry_t;

    entry_t          mem [STACK_DEPTH];

    logic [7:0]      char_reg, char_next;
    logic            last_reg, last_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic            in_num_reg, in_num_next;
    status_t         err_reg, err_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [W-1:0]    top_val_reg, top_val_next;
    op_t             top_op_reg, top_op_next;
    entry_t          rd_reg;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     value_reg, value_next;
    status_t         status_reg, status_next;

    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             is_digit;
    op_t              char_op;
    logic             alu_done;
    logic [W-1:0]     alu_result;
    logic signed [W-1:0] top_signed;

    assign wr_idx     = IDX_W'(sp_reg - 1'b1);
    assign rd_idx     = IDX_W'(sp_reg - 2'd2);
    assign is_digit   = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign top_signed = top_val_reg;

    always_comb
    begin
        unique case (char_reg)
            CH_PLUS:  char_op = OP_ADD;
            CH_MINUS: char_op = OP_SUB;
            CH_STAR:  char_op = OP_MUL;
            CH_SLASH: char_op = OP_DIV;
            default:  char_op = OP_NONE;
        endcase
    end

    ieec_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.op == DP_ALU_START),
        .is_div (top_op_reg == OP_DIV),
        .a      (rd_reg.val),
        .b      (top_val_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_comb
    begin
        char_next      = char_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        in_num_next    = in_num_reg;
        err_next       = err_reg;
        sp_next        = sp_reg;
        top_val_next   = top_val_reg;
        top_op_next    = top_op_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (cmd.op)
            DP_LOAD:
            begin
                char_next = character;
                last_next = is_last;
            end
            DP_DIGIT:
            begin
                acc_next    = {acc_reg[W-4:0], 3'b000} + {acc_reg[W-2:0], 1'b0}
                              + W'(char_reg - CH_ZERO);
                in_num_next = 1'b1;
            end
            DP_DELIVER:
            begin
                top_val_next = acc_reg;
                acc_next     = '0;
                in_num_next  = 1'b0;
            end
            DP_FOLD_ADD:
            begin
                top_val_next = (top_op_reg == OP_ADD) ? (rd_reg.val + top_val_reg)
                                                      : (rd_reg.val - top_val_reg);
                top_op_next  = rd_reg.op;
                sp_next      = sp_reg - 1'b1;
            end
            DP_FOLD_ALU:
            begin
                if (top_op_reg == OP_DIV && top_val_reg == '0)
                begin
                    err_next = ST_DIV_ZERO;
                end
                else
                begin
                    top_val_next = alu_result;
                    top_op_next  = rd_reg.op;
                    sp_next      = sp_reg - 1'b1;
                end
            end
            DP_PUSH:
            begin
                top_val_next = '0;
                top_op_next  = char_op;
                sp_next      = sp_reg + 1'b1;
            end
            DP_POP:
            begin
                // the closed level's value stays on top as the delivered operand
                top_op_next = rd_reg.op;
                sp_next     = sp_reg - 1'b1;
            end
            DP_SET_ERR:
            begin
                err_next = cmd.err;
            end
            DP_FINISH:
            begin
                out_valid_next = 1'b1;
                value_next     = (err_reg == ST_OK) ? 32'(top_signed) : '0;
                status_next    = err_reg;
                acc_next       = '0;
                in_num_next    = 1'b0;
                err_next       = ST_OK;
                sp_next        = SP_W'(1);
                top_val_next   = '0;
                top_op_next    = OP_NONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            acc_reg       <= '0;
            in_num_reg    <= 1'b0;
            err_reg       <= ST_OK;
            sp_reg        <= SP_W'(1);
            top_val_reg   <= '0;
            top_op_reg    <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            acc_reg       <= acc_next;
            in_num_reg    <= in_num_next;
            err_reg       <= err_next;
            sp_reg        <= sp_next;
            top_val_reg   <= top_val_next;
            top_op_reg    <= top_op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // stack below the top entry
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_PUSH)
        begin
            mem[wr_idx] <= '{op: top_op_reg, val: top_val_reg};
        end
        if (cmd.op == DP_READ_BELOW)
        begin
            rd_reg <= mem[rd_idx];
        end
    end

    always_comb
    begin
        if (is_digit)
        begin
            stat.kind = CK_DIGIT;
        end
        else if (char_reg == CH_OPEN)
        begin
            stat.kind = CK_OPEN;
        end
        else if (char_reg == CH_CLOSE)
        begin
            stat.kind = CK_CLOSE;
        end
        else if (char_op == OP_ADD || char_op == OP_SUB)
        begin
            stat.kind = CK_ADDSUB;
        end
        else if (char_op == OP_MUL || char_op == OP_DIV)
        begin
            stat.kind = CK_MULDIV;
        end
        else
        begin
            stat.kind = CK_OTHER;
        end
        stat.last     = last_reg;
        stat.in_num   = in_num_reg;
        stat.err      = (err_reg != ST_OK);
        stat.top_op   = top_op_reg;
        stat.rd_op    = rd_reg.op;
        stat.sp_ge2   = (sp_reg >= SP_W'(2));
        stat.sp_full  = (sp_reg >= SP_W'(STACK_DEPTH));
        stat.sp_is1   = (sp_reg == SP_W'(1));
        stat.alu_done = alu_done;
        stat.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    `IEEC_ASSERT_IMPLY(a_sp_range, clk, rst_n, 1'b1, sp_reg != '0 && sp_reg <= SP_W'(STACK_DEPTH))
    `IEEC_ASSERT_NEXT(a_finish_clears, clk, rst_n, cmd.op == DP_FINISH, out_valid_reg && sp_reg == SP_W'(1) && err_reg == ST_OK)
    `IEEC_ASSERT_NEXT(a_err_sticks, clk, rst_n, err_reg != ST_OK && cmd.op != DP_FINISH, err_reg == $past(err_reg))
    `IEEC_ASSERT_IMPLY(a_base_no_op, clk, rst_n, sp_reg == SP_W'(1), top_op_reg == OP_NONE)

endmodule

/* hw/rtl/ieec_controller.sv */
// ----------------------------------------------------------------------------
// ieec_controller
// Sequencer: decodes each item and walks the stack reductions.
// ----------------------------------------------------------------------------
module ieec_controller
    import ieec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;
    ctl_state_t fold_ret_reg, fold_ret_next;
    ctl_state_t coll_ret_reg, coll_ret_next;

    function automatic logic is_muldiv(input op_t op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fold_ret_reg <= S_IDLE;
            coll_ret_reg <= S_IDLE;
        end
        else
        begin
            state_reg    <= state_next;
            fold_ret_reg <= fold_ret_next;
            coll_ret_reg <= coll_ret_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fold_ret_next = fold_ret_reg;
        coll_ret_next = coll_ret_reg;
        cmd.op        = DP_NOP;
        cmd.err       = ST_OK;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.err)
                begin
                    state_next = S_TAIL;
                end
                else if (stat.kind == CK_DIGIT)
                begin
                    cmd.op     = DP_DIGIT;
                    state_next = S_TAIL;
                end
                else if (stat.in_num)
                begin
                    // a finished number lands on top; fold at once under * or /
                    cmd.op = DP_DELIVER;
                    if (is_muldiv(stat.top_op))
                    begin
                        fold_ret_next = S_CHAR;
                        state_next    = S_FOLD_RD;
                    end
                    else
                    begin
                        state_next = S_CHAR;
                    end
                end
                else
                begin
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                state_next = S_TAIL;
                if (!stat.err)
                begin
                    unique case (stat.kind)
                        CK_OPEN, CK_MULDIV:
                        begin
                            if (stat.sp_full)
                            begin
                                cmd.op  = DP_SET_ERR;
                                cmd.err = ST_TOO_DEEP;
                            end
                            else
                            begin
                                cmd.op = DP_PUSH;
                            end
                        end
                        CK_ADDSUB:
                        begin
                            coll_ret_next = S_OPEN;
                            state_next    = S_COLL;
                        end
                        CK_CLOSE:
                        begin
                            coll_ret_next = S_CLOSE;
                            state_next    = S_COLL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_OPEN:
            begin
                state_next = S_TAIL;
                if (!stat.err)
                begin
                    if (stat.sp_full)
                    begin
                        cmd.op  = DP_SET_ERR;
                        cmd.err = ST_TOO_DEEP;
                    end
                    else
                    begin
                        cmd.op = DP_PUSH;
                    end
                end
            end
            S_CLOSE:
            begin
                state_next = S_TAIL;
                if (!stat.err)
                begin
                    if (!stat.sp_ge2)
                    begin
                        cmd.op  = DP_SET_ERR;
                        cmd.err = ST_UNBALANCED;
                    end
                    else
                    begin
                        cmd.op     = DP_READ_BELOW;
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                cmd.op = DP_POP;
                if (is_muldiv(stat.rd_op))
                begin
                    fold_ret_next = S_TAIL;
                    state_next    = S_FOLD_RD;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    coll_ret_next = S_END_CHK;
                    state_next    = S_COLL;
                    if (!stat.err && stat.in_num)
                    begin
                        cmd.op = DP_DELIVER;
                        if (is_muldiv(stat.top_op))
                        begin
                            fold_ret_next = S_COLL;
                            state_next    = S_FOLD_RD;
                        end
                    end
                end
            end
            S_COLL:
            begin
                if (!stat.err && stat.sp_ge2 && stat.top_op != OP_NONE)
                begin
                    fold_ret_next = S_COLL;
                    state_next    = S_FOLD_RD;
                end
                else
                begin
                    state_next = coll_ret_reg;
                end
            end
            S_END_CHK:
            begin
                if (!stat.err && !stat.sp_is1)
                begin
                    cmd.op  = DP_SET_ERR;
                    cmd.err = ST_UNBALANCED;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the previous result has been taken
                if (!stat.out_busy)
                begin
                    cmd.op     = DP_FINISH;
                    state_next = S_IDLE;
                end
            end
            S_FOLD_RD:
            begin
                cmd.op     = DP_READ_BELOW;
                state_next = S_FOLD_EX;
            end
            S_FOLD_EX:
            begin
                if (stat.top_op == OP_ADD || stat.top_op == OP_SUB)
                begin
                    cmd.op     = DP_FOLD_ADD;
                    state_next = fold_ret_reg;
                end
                else
                begin
                    cmd.op     = DP_ALU_START;
                    state_next = S_FOLD_WAIT;
                end
            end
            S_FOLD_WAIT:
            begin
                if (stat.alu_done)
                begin
                    cmd.op     = DP_FOLD_ALU;
                    state_next = fold_ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
